// File: rtl/ccb_pkg.sv
`default_nettype none
package ccb_pkg;

  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = 16;
  localparam int NUM_PAIRS   = 8;
  // Column step and diagonal step, each split into four add/xor/rotate steps
  localparam int STEPS_PER_DR = 8;
  localparam int STEPS_PER_QR = 4;

  // Position of a word inside one quarter round
  localparam logic [1:0] ROLE_A = 2'd0;
  localparam logic [1:0] ROLE_B = 2'd1;
  localparam logic [1:0] ROLE_C = 2'd2;
  localparam logic [1:0] ROLE_D = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] state_t;

  // Working state plus the original input state, carried for the feed-forward
  typedef struct packed {
    state_t work;
    state_t init;
  } pipe_t;

  // State index of one role of quarter round q; diagonal rounds skew rows b, c, d
  function automatic logic [3:0] ccb_idx(input logic diag, input logic [1:0] q,
                                         input logic [1:0] role);
    logic [1:0] col;
    col = q;
    unique case (role)
      ROLE_A: col = q;
      ROLE_B: col = q + {1'b0, diag};
      ROLE_C: col = q + {diag, 1'b0};
      ROLE_D: col = q + {diag, diag};
      default: col = q;
    endcase
    return {role, col};
  endfunction

  // Rotate amount of each step of the quarter round
  function automatic int ccb_rot(input int step);
    int r;
    r = 16;
    unique case (step)
      0: r = 16;
      1: r = 12;
      2: r = 8;
      3: r = 7;
      default: r = 16;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ccb_round_stage.sv
`default_nettype none
module ccb_round_stage #(
  parameter int STEP = 0,
  parameter bit DIAG = 1'b0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          d_valid,
  input  wire ccb_pkg::pipe_t d_in,
  output      logic          q_valid,
  output      ccb_pkg::pipe_t q_out
);
  import ccb_pkg::*;

  localparam int ROT = ccb_rot(STEP);
  localparam bit UPDATE_D = ((STEP % 2) == 0);

  pipe_t nxt;

  // One add/xor/rotate step on all four quarter rounds in parallel
  always_comb begin
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    word_t      sum;
    word_t      mix;
    nxt = d_in;
    for (int q = 0; q < 4; q++) begin
      ia = ccb_idx(DIAG, 2'(q), ROLE_A);
      ib = ccb_idx(DIAG, 2'(q), ROLE_B);
      ic = ccb_idx(DIAG, 2'(q), ROLE_C);
      id = ccb_idx(DIAG, 2'(q), ROLE_D);
      if (UPDATE_D) begin
        sum = d_in.work[ia] + d_in.work[ib];
        mix = d_in.work[id] ^ sum;
        nxt.work[ia] = sum;
        nxt.work[id] = {mix[WORD_W-1-ROT:0], mix[WORD_W-1:WORD_W-ROT]};
      end else begin
        sum = d_in.work[ic] + d_in.work[id];
        mix = d_in.work[ib] ^ sum;
        nxt.work[ic] = sum;
        nxt.work[ib] = {mix[WORD_W-1-ROT:0], mix[WORD_W-1:WORD_W-ROT]};
      end
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      q_out <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccb_final_add.sv
`default_nettype none
module ccb_final_add (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           d_valid,
  input  wire ccb_pkg::pipe_t  d_in,
  output      logic           q_valid,
  output      ccb_pkg::state_t q_sum
);
  import ccb_pkg::*;

  state_t sum;

  // Feed-forward: add the original state word by word
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      sum[k] = d_in.work[k] + d_in.init[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_sum <= sum;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ccb_out_skid.sv
`default_nettype none
module ccb_out_skid (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           d_valid,
  output      logic           d_ready,
  input  wire ccb_pkg::state_t d_data,
  output      logic           q_valid,
  input  wire logic           q_ready,
  output      ccb_pkg::state_t q_data
);
  import ccb_pkg::*;

  logic   skid_valid;
  state_t skid_data;
  logic   out_load;

  // Upstream moves whenever the skid slot is free
  assign d_ready  = !skid_valid;
  assign out_load = !q_valid || q_ready;

  // Control: output register refills from skid first, else from upstream
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      q_valid    <= skid_valid || d_valid;
      skid_valid <= 1'b0;
    end else if (d_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (out_load) begin
      q_data <= skid_valid ? skid_data : d_data;
    end else if (!skid_valid) begin
      skid_data <= d_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/chacha20_block_keystream_unit.sv
// ChaCha20 block function, fully pipelined keystream generator.
// Input channel: in_valid / in_ready with the 16-word state packed as
// in_pair_0..7 (even state word in bits 31:0, odd one in bits 63:32).
// Output channel: out_valid / out_ready with the 64-byte keystream block
// as out_bytes_0..7, little-endian (byte 8k in bits 7:0 of out_bytes_k).
// Each double round is unrolled into 8 register stages, one 32-bit add,
// xor and rotate per stage on all four quarter rounds, followed by one
// feed-forward add stage and an output register with a skid slot.
// A new input state is taken whenever in_ready is high, even while earlier
// blocks are still in the pipeline.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the skid slot takes one more result, then
// in_ready falls and the whole pipeline holds its contents until the
// output drains; nothing is dropped or repeated.
`default_nettype none
module chacha20_block_keystream_unit #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [63:0] in_pair_0,
  input  wire logic [63:0] in_pair_1,
  input  wire logic [63:0] in_pair_2,
  input  wire logic [63:0] in_pair_3,
  input  wire logic [63:0] in_pair_4,
  input  wire logic [63:0] in_pair_5,
  input  wire logic [63:0] in_pair_6,
  input  wire logic [63:0] in_pair_7,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [63:0] out_bytes_0,
  output      logic [63:0] out_bytes_1,
  output      logic [63:0] out_bytes_2,
  output      logic [63:0] out_bytes_3,
  output      logic [63:0] out_bytes_4,
  output      logic [63:0] out_bytes_5,
  output      logic [63:0] out_bytes_6,
  output      logic [63:0] out_bytes_7
);
  import ccb_pkg::*;

  localparam int NUM_STAGES = DOUBLE_ROUNDS * STEPS_PER_DR;

  logic [NUM_STAGES:0] pipe_valid;
  pipe_t               pipe_data [NUM_STAGES+1];
  logic                adv;
  logic                sum_valid;
  state_t              sum_data;
  state_t              res;
  logic [63:0]         pairs [NUM_PAIRS];

  assign pairs[0] = in_pair_0;
  assign pairs[1] = in_pair_1;
  assign pairs[2] = in_pair_2;
  assign pairs[3] = in_pair_3;
  assign pairs[4] = in_pair_4;
  assign pairs[5] = in_pair_5;
  assign pairs[6] = in_pair_6;
  assign pairs[7] = in_pair_7;

  // Unpack input pairs into the working and original state
  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      pipe_data[0].work[2*k]     = pairs[k][31:0];
      pipe_data[0].work[2*k + 1] = pairs[k][63:32];
    end
    pipe_data[0].init = pipe_data[0].work;
  end

  assign in_ready      = adv;
  assign pipe_valid[0] = in_valid;

  // Round pipeline: column steps then diagonal steps, four each
  for (genvar gi = 0; gi < NUM_STAGES; gi++) begin : g_stage
    ccb_round_stage #(
      .STEP(gi % STEPS_PER_QR),
      .DIAG(1'((gi / STEPS_PER_QR) % 2))
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .d_valid (pipe_valid[gi]),
      .d_in    (pipe_data[gi]),
      .q_valid (pipe_valid[gi+1]),
      .q_out   (pipe_data[gi+1])
    );
  end

  ccb_final_add u_final (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .d_valid (pipe_valid[NUM_STAGES]),
    .d_in    (pipe_data[NUM_STAGES]),
    .q_valid (sum_valid),
    .q_sum   (sum_data)
  );

  ccb_out_skid u_out (
    .clk     (clk),
    .rst     (rst),
    .d_valid (sum_valid),
    .d_ready (adv),
    .d_data  (sum_data),
    .q_valid (out_valid),
    .q_ready (out_ready),
    .q_data  (res)
  );

  // Little-endian serialization equals word pairs
  assign out_bytes_0 = {res[1],  res[0]};
  assign out_bytes_1 = {res[3],  res[2]};
  assign out_bytes_2 = {res[5],  res[4]};
  assign out_bytes_3 = {res[7],  res[6]};
  assign out_bytes_4 = {res[9],  res[8]};
  assign out_bytes_5 = {res[11], res[10]};
  assign out_bytes_6 = {res[13], res[12]};
  assign out_bytes_7 = {res[15], res[14]};

endmodule
`default_nettype wire
